// ----- rtl/core/vnn_pkg.sv -----
// Shared constants and types for the vector norm normalizer
`default_nettype none

package vnn_pkg;

   localparam int MAX_LEN_DEF     = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int ACC_W       = 37;
   localparam int NORM_FRAC   = 8;
   localparam int FRAC_SHIFT  = 23;
   localparam int DIV_STEPS   = 16;
   localparam int OUT_W       = 16;
   localparam int MODE_W      = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
   localparam logic [OUT_W-1:0] Q_POS_MAX = 16'h7FFF;
   localparam logic [OUT_W:0]   Q_NEG_MAG = 17'h08000;

   localparam logic [MODE_W-1:0] MODE_L2 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_L1 = 2'd1;

   localparam logic REG_NORM_MODE = 1'b0;

   typedef enum logic [2:0] {
      S_LOAD,
      S_DRAIN,
      S_NORM,
      S_ROOT,
      S_READ,
      S_SETUP,
      S_DIV,
      S_OUT
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/vnn_if.sv -----
// Valid/ready channel interfaces for samples and scaled results
`default_nettype none

interface vnn_req_if #(
   parameter int SAMPLE_BITS = vnn_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface vnn_rsp_if;
   import vnn_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] scaled_value;
   logic                    last_value;
   logic                    overflowed;

   modport source (output valid, output scaled_value, output last_value, output overflowed,
                   input ready);
   modport sink   (input valid, input scaled_value, input last_value, input overflowed,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/core/vnn_cmpsub.sv -----
// Shared compare-and-subtract unit used by the root and divide iterations
`default_nettype none

module vnn_cmpsub #(
   parameter int WIDTH = 62
) (
   input  wire logic [WIDTH-1:0] op_a,
   input  wire logic [WIDTH-1:0] op_b,
   output logic                  a_ge_b,
   output logic [WIDTH-1:0]      diff
);

   logic [WIDTH:0] wide_diff;

   always_comb begin
      wide_diff = {1'b0, op_a} - {1'b0, op_b};
      a_ge_b    = ~wide_diff[WIDTH];
      diff      = wide_diff[WIDTH-1:0];
   end

endmodule

`default_nettype wire

// ----- rtl/core/vector_norm_normalizer.sv -----
// Vector normalizer: L2 / L1 / max-magnitude norm, elements scaled to signed Q1.15
//
// Samples arrive on req_if (valid/ready); one is taken per cycle while loading.
// A transaction with last_sample set closes the vector. Results leave on rsp_if,
// one per stored element in arrival order, last_value on the final one and
// overflowed on all of them when samples beyond MAX_LEN were dropped.
// After the closing transaction the norm settles (drain, norm states), followed
// by the square root in L2 mode. Each element then passes store read, setup,
// 16 divide steps and output, and waits while the receiver holds rsp_if.ready
// low; one compare-subtract unit carries the root and the divide, one bit per
// cycle. req_if.ready stays low from the closing transaction until the final
// result is taken. A stalled result holds in its register until taken.
// norm_mode is written over the APB port at byte 0; it applies to each sample
// as it arrives, and the mode at the closing sample picks the norm.
// Synchronous reset clears the sequencer, sample count, drop flag, accumulator and the mode
// register; the sample store holds no reset state.
`default_nettype none

module vector_norm_normalizer #(
   parameter int MAX_LEN     = vnn_pkg::MAX_LEN_DEF,
   parameter int SAMPLE_BITS = vnn_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   vnn_req_if.sink                              req_if,
   vnn_rsp_if.source                            rsp_if,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [vnn_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [vnn_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [vnn_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);
   import vnn_pkg::*;

   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int PEND_W = 2 * SAMPLE_BITS;
   localparam int SUM_W  = ((ACC_W > PEND_W) ? ACC_W : PEND_W) + 1;
   localparam int NW     = ACC_W + NORM_FRAC;
   localparam int SQ_W   = ACC_W + 2 * NORM_FRAC + 1;
   localparam int ROOT_STEPS = SQ_W / 2;
   localparam int DVD_W  = ((SAMPLE_BITS + FRAC_SHIFT > NW) ? SAMPLE_BITS + FRAC_SHIFT : NW) + 1;
   localparam int CW0    = (NW + DIV_STEPS + 1 > DVD_W) ? NW + DIV_STEPS + 1 : DVD_W;
   localparam int CW     = (CW0 > SQ_W) ? CW0 : SQ_W;
   localparam int SW     = $clog2(DIV_STEPS);

   state_type               state_ff, state_in;
   logic [MODE_W-1:0]       mode_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic                    drop_ff, drop_in;
   logic                    pend_vld_ff, pend_vld_in;
   logic                    pend_max_ff, pend_max_in;
   logic [PEND_W-1:0]       pend_val_ff, pend_val_in;
   logic                    l2_ff, l2_in;
   logic [NW-1:0]           norm_ff, norm_in;
   logic [CW-1:0]           rem_ff, rem_in;
   logic [CW-1:0]           dsh_ff, dsh_in;
   logic [SQ_W-1:0]         root_ff, root_in;
   logic [DIV_STEPS-1:0]    quot_ff, quot_in;
   logic [SW-1:0]           step_ff, step_in;
   logic                    ovf_ff, ovf_in;
   logic                    zero_ff, zero_in;
   logic                    neg_ff, neg_in;
   logic [CNT_W-1:0]        elem_ff, elem_in;
   logic [OUT_W-1:0]        rsp_val_ff, rsp_val_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic [SAMPLE_BITS-1:0]  store [MAX_LEN];
   logic [SAMPLE_BITS-1:0]  rd_data_ff;
   logic                    wr_en;

   logic                    rsp_xact, csr_write;
   logic [SAMPLE_BITS-1:0]  in_mag, rd_mag;
   logic [PEND_W-1:0]       in_sq;
   logic [SUM_W-1:0]        acc_sum;
   logic [ACC_W-1:0]        acc_upd;
   logic [DVD_W-1:0]        dividend;
   logic [CW-1:0]           cs_a, cs_b, cs_diff;
   logic                    cs_ge;
   logic [SQ_W-1:0]         root_next;
   logic [DIV_STEPS-1:0]    quot_next;
   logic [OUT_W:0]          neg_mag;

   assign rsp_xact  = rsp_if.valid & rsp_if.ready;
   assign csr_write = psel & penable & pwrite & pready;

   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1] == REG_NORM_MODE) ?
                   CSR_DATA_W'(mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_L2;
      end else if (csr_write && paddr[CSR_ADDR_W-1] == REG_NORM_MODE) begin
         mode_ff <= pwdata[MODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[count_ff[AW-1:0]] <= SAMPLE_BITS'(req_if.sample);
      end
      rd_data_ff <= store[elem_ff[AW-1:0]];
   end

   vnn_cmpsub #(.WIDTH(CW)) u_cmpsub (
      .op_a   (cs_a),
      .op_b   (cs_b),
      .a_ge_b (cs_ge),
      .diff   (cs_diff)
   );

   always_comb begin
      in_mag = req_if.sample[SAMPLE_BITS-1] ?
               SAMPLE_BITS'(~req_if.sample) + SAMPLE_BITS'(1) : SAMPLE_BITS'(req_if.sample);
      rd_mag = rd_data_ff[SAMPLE_BITS-1] ?
               ~rd_data_ff + SAMPLE_BITS'(1) : rd_data_ff;
      in_sq  = PEND_W'(in_mag) * PEND_W'(in_mag);

      acc_sum = SUM_W'(acc_ff) + SUM_W'(pend_val_ff);
      acc_upd = acc_ff;
      if (pend_vld_ff) begin
         if (pend_max_ff) begin
            if (SUM_W'(pend_val_ff) > SUM_W'(acc_ff)) begin
               acc_upd = ACC_W'(pend_val_ff);
            end
         end else begin
            acc_upd = (acc_sum > SUM_W'(ACC_MAX)) ? ACC_MAX : ACC_W'(acc_sum);
         end
      end

      dividend = (DVD_W'(rd_mag) << FRAC_SHIFT) + DVD_W'(norm_ff >> 1);

      case (state_ff)
         S_ROOT: begin
            cs_a = rem_ff;
            cs_b = dsh_ff | CW'(root_ff);
         end
         S_SETUP: begin
            cs_a = CW'(dividend);
            cs_b = CW'(norm_ff) << DIV_STEPS;
         end
         default: begin
            cs_a = rem_ff;
            cs_b = dsh_ff;
         end
      endcase

      root_next = cs_ge ? ((root_ff >> 1) | SQ_W'(dsh_ff)) : (root_ff >> 1);
      quot_next = {quot_ff[DIV_STEPS-2:0], cs_ge};
      neg_mag   = (ovf_ff || quot_next > DIV_STEPS'(Q_NEG_MAG)) ?
                  Q_NEG_MAG : {1'b0, quot_next};
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      acc_in      = acc_upd;
      drop_in     = drop_ff;
      pend_vld_in = 1'b0;
      pend_max_in = pend_max_ff;
      pend_val_in = pend_val_ff;
      l2_in       = l2_ff;
      norm_in     = norm_ff;
      rem_in      = rem_ff;
      dsh_in      = dsh_ff;
      root_in     = root_ff;
      quot_in     = quot_ff;
      step_in     = step_ff;
      ovf_in      = ovf_ff;
      zero_in     = zero_ff;
      neg_in      = neg_ff;
      elem_in     = elem_ff;
      rsp_val_in  = rsp_val_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      wr_en       = 1'b0;
      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;

      case (state_ff)
         S_LOAD: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               if (count_ff < CNT_W'(MAX_LEN)) begin
                  wr_en       = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
                  pend_vld_in = 1'b1;
                  pend_max_in = (mode_ff != MODE_L2) && (mode_ff != MODE_L1);
                  pend_val_in = (mode_ff == MODE_L2) ? in_sq : PEND_W'(in_mag);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_if.last_sample) begin
                  l2_in    = (mode_ff == MODE_L2);
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            state_in = S_NORM;
         end
         S_NORM: begin
            elem_in = '0;
            if (acc_ff == '0) begin
               norm_in  = '0;
               state_in = S_READ;
            end else if (l2_ff) begin
               rem_in   = CW'(acc_ff) << (2 * NORM_FRAC);
               dsh_in   = CW'(1) << (2 * (ROOT_STEPS - 1));
               root_in  = '0;
               state_in = S_ROOT;
            end else begin
               norm_in  = NW'(acc_ff) << NORM_FRAC;
               state_in = S_READ;
            end
         end
         S_ROOT: begin
            if (cs_ge) begin
               rem_in = cs_diff;
            end
            root_in = root_next;
            dsh_in  = dsh_ff >> 2;
            if (dsh_ff == CW'(1)) begin
               norm_in  = NW'(root_next);
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_SETUP;
         end
         S_SETUP: begin
            zero_in  = (norm_ff == '0);
            ovf_in   = cs_ge && (norm_ff != '0);
            neg_in   = rd_data_ff[SAMPLE_BITS-1];
            rem_in   = CW'(dividend);
            dsh_in   = CW'(norm_ff) << (DIV_STEPS - 1);
            quot_in  = '0;
            step_in  = SW'(DIV_STEPS - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (cs_ge) begin
               rem_in = cs_diff;
            end
            quot_in = quot_next;
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff - SW'(1);
            if (step_ff == '0) begin
               if (zero_ff) begin
                  rsp_val_in = '0;
               end else if (neg_ff) begin
                  rsp_val_in = OUT_W'(~neg_mag + (OUT_W + 1)'(1));
               end else begin
                  rsp_val_in = (ovf_ff || quot_next > Q_POS_MAX) ? Q_POS_MAX : quot_next;
               end
               rsp_last_in = ((elem_ff + CNT_W'(1)) == count_ff);
               rsp_ovf_in  = drop_ff;
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            rsp_if.valid = 1'b1;
            if (rsp_if.ready) begin
               if (rsp_last_ff) begin
                  count_in = '0;
                  acc_in   = '0;
                  drop_in  = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  elem_in  = elem_ff + CNT_W'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   assign rsp_if.scaled_value = rsp_val_ff;
   assign rsp_if.last_value   = rsp_last_ff;
   assign rsp_if.overflowed   = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         count_ff    <= '0;
         acc_ff      <= '0;
         drop_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         acc_ff      <= acc_in;
         drop_ff     <= drop_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_max_ff <= pend_max_in;
      pend_val_ff <= pend_val_in;
      l2_ff       <= l2_in;
      norm_ff     <= norm_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      root_ff     <= root_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      ovf_ff      <= ovf_in;
      zero_ff     <= zero_in;
      neg_ff      <= neg_in;
      elem_ff     <= elem_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LEN))
      else $error("element count beyond store depth");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_xact && rsp_last_ff) |=> (count_ff == '0 && acc_ff == '0 && !drop_ff))
      else $error("vector state not cleared after final transaction");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && !zero_ff && !ovf_ff) |-> ({1'b0, rem_ff} < {dsh_ff, 1'b0}))
      else $error("divide remainder out of range");

   a_pend_in_load: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (state_ff == S_LOAD || state_ff == S_DRAIN))
      else $error("accumulate pending outside load");

   a_elem_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (elem_ff < count_ff))
      else $error("emitting past stored elements");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_vector_norm_normalizer.sv -----
// Self-checking testbench for the vector norm normalizer
`timescale 1ns / 100ps

module tb_vector_norm_normalizer;
   import vnn_pkg::*;

   localparam logic [MODE_W-1:0] MODE_MAX    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] ADDR_NORM_MODE = CSR_ADDR_W'(4 * REG_NORM_MODE);
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE     = CSR_ADDR_W'(4);

   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TARGET_SAMPLES = 370;

   typedef struct packed {
      logic signed [OUT_W-1:0] scaled_value;
      logic                    last_value;
      logic                    overflowed;
   } scaled_result_t;

   logic clock = 1'b0;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   vnn_req_if sample_ch ();
   vnn_rsp_if result_ch ();

   vector_norm_normalizer dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (sample_ch),
      .rsp_if  (result_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor state
   logic [MODE_W-1:0]             norm_mode;
   logic signed [15:0]            vector_store [MAX_LEN_DEF];
   int                            stored_count;
   logic [63:0]                   norm_acc;
   logic                          dropped;
   scaled_result_t                expected_results [$];

   int   error_count   = 0;
   int   samples_sent  = 0;
   int   stall_cycles  = 0;
   logic steady        = 1'b0;

   always #1 clock = ~clock;

   always @(negedge clock) begin
      result_ch.ready <= steady || ($urandom_range(99) >= 23);
   end

   function automatic logic [63:0] magnitude(logic signed [15:0] s);
      return s[15] ? (64'h10000 - {48'd0, s}) : {48'd0, s};
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      int          b;
      r = 64'd0;
      for (b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   task automatic accumulate_sample(input logic signed [15:0] s, input logic last);
      logic [MODE_W-1:0] m;
      logic [63:0]       mag;
      logic [63:0]       acc;
      logic [63:0]       nrm;
      logic [63:0]       q;
      scaled_result_t    r;
      int                i;
      m = (norm_mode == MODE_UNUSED) ? MODE_MAX : norm_mode;
      mag = magnitude(s);
      if (stored_count < MAX_LEN_DEF) begin
         vector_store[stored_count] = s;
         stored_count++;
         case (m)
            MODE_L2: acc = norm_acc + mag * mag;
            MODE_L1: acc = norm_acc + mag;
            default: acc = (mag > norm_acc) ? mag : norm_acc;
         endcase
         norm_acc = (acc > ACC_MAX) ? 64'(ACC_MAX) : acc;
      end else begin
         dropped = 1'b1;
      end
      if (!last) return;
      if (norm_acc == 0) nrm = 64'd0;
      else if (m == MODE_L2) nrm = root_floor(norm_acc << (2 * NORM_FRAC));
      else nrm = norm_acc << NORM_FRAC;
      for (i = 0; i < stored_count; i++) begin
         q = (nrm == 0) ? 64'd0
                        : ((magnitude(vector_store[i]) << FRAC_SHIFT) + (nrm >> 1)) / nrm;
         if (vector_store[i] < 0) begin
            r.scaled_value = (q > Q_NEG_MAG) ? 16'sh8000 : -q[15:0];
         end else begin
            r.scaled_value = (q > Q_POS_MAX) ? Q_POS_MAX : q[15:0];
         end
         r.last_value = (i == stored_count - 1);
         r.overflowed = dropped;
         expected_results.push_back(r);
      end
      stored_count = 0;
      norm_acc = 64'd0;
      dropped = 1'b0;
   endtask

   always @(posedge clock) begin
      scaled_result_t want;
      if (!reset && result_ch.valid && result_ch.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result scaled_value=%0d last_value=%0b overflowed=%0b",
                     $time, result_ch.scaled_value, result_ch.last_value,
                     result_ch.overflowed);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (result_ch.scaled_value !== want.scaled_value) begin
               $display("%0t: scaled_value expected %0d actual %0d", $time,
                        want.scaled_value, result_ch.scaled_value);
               error_count++;
            end
            if (result_ch.last_value !== want.last_value) begin
               $display("%0t: last_value expected %0b actual %0b", $time,
                        want.last_value, result_ch.last_value);
               error_count++;
            end
            if (result_ch.overflowed !== want.overflowed) begin
               $display("%0t: overflowed expected %0b actual %0b", $time,
                        want.overflowed, result_ch.overflowed);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
          || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
         $display("vector_norm_normalizer test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_sample(input logic signed [15:0] s, input logic last);
      if (!steady) begin
         while ($urandom_range(99) < 23) begin
            sample_ch.valid <= 1'b0;
            @(negedge clock);
         end
      end
      sample_ch.valid       <= 1'b1;
      sample_ch.sample      <= s;
      sample_ch.last_sample <= last;
      @(posedge clock);
      while (!sample_ch.ready) @(posedge clock);
      accumulate_sample(s, last);
      samples_sent++;
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3, 4, 5: return 16'($signed($urandom_range(511)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_vector(input int len);
      int k;
      for (k = 0; k < len; k++) send_sample(pick_sample(), k == len - 1);
   endtask

   task automatic wait_idle();
      sample_ch.valid <= 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == ADDR_NORM_MODE) norm_mode = data[MODE_W-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_mode_readback();
      logic [CSR_DATA_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_NORM_MODE;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      if (got !== CSR_DATA_W'(norm_mode)) begin
         $display("%0t: norm_mode readback expected %0d actual %0d", $time, norm_mode, got);
         error_count++;
      end
   endtask

   task automatic set_mode(input logic [MODE_W-1:0] m);
      wait_idle();
      csr_write(ADDR_NORM_MODE, CSR_DATA_W'(m));
      check_mode_readback();
   endtask

   task automatic test_reset_mode();
      check_mode_readback();
      send_sample(16'sd3, 1'b0);
      send_sample(16'sd4, 1'b1);
   endtask

   task automatic test_extremes();
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b1);
   endtask

   // a lone element is +/-1.0 of its own norm; +1.0 saturates
   task automatic test_unit_vectors();
      set_mode(MODE_L1);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7FFF, 1'b1);
   endtask

   task automatic test_zero_norm();
      set_mode(MODE_MAX);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b1);
   endtask

   task automatic test_unused_mode();
      set_mode(MODE_UNUSED);
      send_sample(16'sd100, 1'b0);
      send_sample(-16'sd200, 1'b1);
   endtask

   task automatic test_mode_switch_in_vector();
      set_mode(MODE_L2);
      send_sample(16'sd1000, 1'b0);
      send_sample(-16'sd500, 1'b0);
      set_mode(MODE_L1);
      send_sample(16'sd7, 1'b1);
   endtask

   task automatic test_spare_register();
      wait_idle();
      csr_write(ADDR_SPARE, CSR_DATA_W'(MODE_MAX));
      check_mode_readback();
      send_sample(16'sd5, 1'b0);
      send_sample(-16'sd5, 1'b1);
   endtask

   // the closing sample is dropped in both vectors: one beyond MAX_LEN in the first, six in the second
   task automatic test_overflow();
      set_mode(MODE_L2);
      send_vector(MAX_LEN_DEF + 1);
      set_mode(MODE_MAX);
      send_vector(MAX_LEN_DEF + 6);
   endtask

   task automatic test_steady_stream();
      int start;
      set_mode(logic'($urandom_range(1)) ? MODE_L1 : MODE_L2);
      steady = 1'b1;
      start = samples_sent;
      while (samples_sent - start < 60) send_vector($urandom_range(1, 16));
      wait_idle();
      steady = 1'b0;
   endtask

   task automatic test_random_vectors();
      int pick;
      while (samples_sent < TARGET_SAMPLES) begin
         if ($urandom_range(99) < 30) set_mode(MODE_W'($urandom_range(3)));
         pick = $urandom_range(99);
         if (pick < 80) send_vector($urandom_range(1, 12));
         else if (pick < 95) send_vector($urandom_range(13, MAX_LEN_DEF));
         else send_vector($urandom_range(MAX_LEN_DEF, MAX_LEN_DEF + 3));
      end
   endtask

   initial begin
      reset                 = 1'b1;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      sample_ch.valid       = 1'b0;
      sample_ch.sample      = '0;
      sample_ch.last_sample = 1'b0;
      norm_mode             = MODE_L2;
      stored_count          = 0;
      norm_acc              = 64'd0;
      dropped               = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_mode();
      test_extremes();
      test_unit_vectors();
      test_zero_norm();
      test_unused_mode();
      test_mode_switch_in_vector();
      test_spare_register();
      test_overflow();
      test_steady_stream();
      test_random_vectors();

      wait_idle();
      if (error_count == 0) begin
         $display("vector_norm_normalizer test passed");
      end else begin
         $display("vector_norm_normalizer test failed");
      end
      $finish;
   end

endmodule
